### hw/rtl/lprc_pkg.sv
package lprc_pkg;

  // field widths
  localparam int unsigned COORD_W   = 20;
  localparam int unsigned CFG_W     = 27;
  localparam int unsigned CFG_IDX_W = 3;

  // angle format, 2^-24 rad units, signed
  localparam int unsigned ANG_W = 28;
  localparam logic signed [ANG_W-1:0] ANG_PI      = 28'sd52707179;
  localparam logic signed [ANG_W:0]   ANG_PI_HALF = 29'sd26353589;

  // cordic datapath
  localparam int unsigned CORD_W       = 53;
  localparam int unsigned CORDIC_STEPS = 24;

  // integer square root of (x^2 + y^2) << 20
  localparam int unsigned SQRT_RAD_W  = 60;
  localparam int unsigned SQRT_ROOT_W = 30;
  localparam int unsigned SQRT_REM_W  = 32;

  // restoring divider
  localparam int unsigned DIV_NUM_W = 28;
  localparam int unsigned DIV_DEN_W = 25;

  // squared range threshold, 100 mm
  localparam logic [40:0] MIN_RANGE_SQ = 41'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT        = 3'd0,
    CFG_COLUMN_COUNT     = 3'd1,
    CFG_ELEVATION_OFFSET = 3'd2,
    CFG_VERTICAL_STEP    = 3'd3,
    CFG_HORIZONTAL_STEP  = 3'd4
  } cfg_idx_e;

  // round(atan(2^-i) * 2^24)
  function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned idx);
    case (idx)
      0:       return 28'sd13176795;
      1:       return 28'sd7778716;
      2:       return 28'sd4110060;
      3:       return 28'sd2086331;
      4:       return 28'sd1047214;
      5:       return 28'sd524117;
      6:       return 28'sd262123;
      7:       return 28'sd131069;
      8:       return 28'sd65536;
      9:       return 28'sd32768;
      10:      return 28'sd16384;
      11:      return 28'sd8192;
      12:      return 28'sd4096;
      13:      return 28'sd2048;
      14:      return 28'sd1024;
      15:      return 28'sd512;
      16:      return 28'sd256;
      17:      return 28'sd128;
      18:      return 28'sd64;
      19:      return 28'sd32;
      20:      return 28'sd16;
      21:      return 28'sd8;
      22:      return 28'sd4;
      23:      return 28'sd2;
      default: return '0;
    endcase
  endfunction

endpackage

### hw/rtl/lidar_point_to_range_cell.sv
// Lidar point to range-image cell. Takes one point (x, y, z in signed mm) per
// transaction and returns the row, column and flat cell index it falls in, or
// valid_res = 0 when the point is closer than 100 mm or lands outside the
// image. Fully pipelined: one point per clock cycle sustained while in_stall_o
// is low. Between input acceptance and the output register, each point passes
// through a chain of pipeline cells and registers: 30 square-root
// cells, 24 cordic cells (elevation and azimuth side by side) and 28 divider
// cells (row and column side by side), plus five staging registers. A
// two-entry output buffer lets the input keep accepting while a result waits.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i and must
// only change while no point is in flight.
module lidar_point_to_range_cell #(
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned MAX_COLUMNS = 2048
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lprc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [lprc_pkg::CFG_W-1:0]             cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [lprc_pkg::COORD_W-1:0]    x_mm_i,
  input  logic signed [lprc_pkg::COORD_W-1:0]    y_mm_i,
  input  logic signed [lprc_pkg::COORD_W-1:0]    z_mm_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   valid_res_o,
  output logic [5:0]                             row_o,
  output logic [10:0]                            column_o,
  output logic [16:0]                            cell_index_o
);

  localparam int unsigned CW    = lprc_pkg::COORD_W;
  localparam int unsigned KW    = lprc_pkg::CORD_W;
  localparam int unsigned AW    = lprc_pkg::ANG_W;
  localparam int unsigned SQ_N  = lprc_pkg::SQRT_ROOT_W;
  localparam int unsigned CO_N  = lprc_pkg::CORDIC_STEPS;
  localparam int unsigned DV_N  = lprc_pkg::DIV_NUM_W;
  localparam int unsigned NSTG  = 2 + SQ_N + 1 + CO_N + 1 + DV_N + 1;
  localparam int unsigned SQ_TW = 3 * CW + 1;

  localparam logic [7:0]  ROWS_LIM = 8'(MAX_ROWS);
  localparam logic [12:0] COLS_LIM = 13'(MAX_COLUMNS);

  // configuration registers
  logic [6:0]         row_count_q;
  logic [11:0]        column_count_q;
  logic signed [26:0] elev_offset_q;
  logic [23:0]        vert_step_q;
  logic [23:0]        horiz_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= 7'd16;
      column_count_q <= 12'd1800;
      elev_offset_q  <= '0;
      vert_step_q    <= 24'd33554;
      horiz_step_q   <= 24'd58565;
    end else if (cfg_we_i) begin
      case (lprc_pkg::cfg_idx_e'(cfg_idx_i))
        lprc_pkg::CFG_ROW_COUNT:        row_count_q    <= cfg_data_i[6:0];
        lprc_pkg::CFG_COLUMN_COUNT:     column_count_q <= cfg_data_i[11:0];
        lprc_pkg::CFG_ELEVATION_OFFSET: elev_offset_q  <= cfg_data_i;
        lprc_pkg::CFG_VERTICAL_STEP:    vert_step_q    <= cfg_data_i[23:0];
        lprc_pkg::CFG_HORIZONTAL_STEP:  horiz_step_q   <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // clamped counts
  logic [7:0]  rows;
  logic [12:0] cols;
  assign rows = ({1'b0, row_count_q} > ROWS_LIM) ? ROWS_LIM : {1'b0, row_count_q};
  assign cols = ({1'b0, column_count_q} > COLS_LIM) ? COLS_LIM : {1'b0, column_count_q};

  // pipeline advance and valid chain
  logic            en;
  logic            skid_v_q;
  logic [NSTG-1:0] vld_q;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // input register
  logic signed [CW-1:0] a_x_q, a_y_q, a_z_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_x_q <= x_mm_i;
      a_y_q <= y_mm_i;
      a_z_q <= z_mm_i;
    end
  end

  // squares and range threshold
  logic [39:0]          xx, yy, zz, hsq;
  logic [40:0]          rsq;
  logic [39:0]          b_hsq_q;
  logic                 b_ok_q;
  logic signed [CW-1:0] b_x_q, b_y_q, b_z_q;

  assign xx  = 40'(a_x_q * a_x_q);
  assign yy  = 40'(a_y_q * a_y_q);
  assign zz  = 40'(a_z_q * a_z_q);
  assign hsq = xx + yy;
  assign rsq = {1'b0, hsq} + {1'b0, zz};

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_hsq_q <= hsq;
      b_ok_q  <= (rsq >= lprc_pkg::MIN_RANGE_SQ);
      b_x_q   <= a_x_q;
      b_y_q   <= a_y_q;
      b_z_q   <= a_z_q;
    end
  end

  // square root chain
  logic [lprc_pkg::SQRT_RAD_W-1:0]  sq_rad  [SQ_N+1];
  logic [lprc_pkg::SQRT_ROOT_W-1:0] sq_root [SQ_N+1];
  logic [lprc_pkg::SQRT_REM_W-1:0]  sq_rem  [SQ_N+1];
  logic [SQ_TW-1:0]                 sq_tag  [SQ_N+1];

  assign sq_rad[0]  = {b_hsq_q, 20'b0};
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_tag[0]  = {b_x_q, b_y_q, b_z_q, b_ok_q};

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    lprc_sqrt_cell #(.TAG_W(SQ_TW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (sq_rad[i]),
      .root_i (sq_root[i]),
      .rem_i  (sq_rem[i]),
      .tag_i  (sq_tag[i]),
      .rad_o  (sq_rad[i+1]),
      .root_o (sq_root[i+1]),
      .rem_o  (sq_rem[i+1]),
      .tag_o  (sq_tag[i+1])
    );
  end

  // cordic input vectors, azimuth pre-rotated into the right half plane
  logic signed [CW-1:0] p_x, p_y, p_z;
  logic signed [KW-1:0] az_ay, az_bx;
  logic signed [KW-1:0] p_elx_q, p_ely_q, p_azx_q, p_azy_q;
  logic signed [AW-1:0] p_azang_q;
  logic                 p_ok_q, p_zero_q;

  assign p_x   = sq_tag[SQ_N][SQ_TW-1 -: CW];
  assign p_y   = sq_tag[SQ_N][SQ_TW-CW-1 -: CW];
  assign p_z   = sq_tag[SQ_N][CW:1];
  assign az_ay = {{(KW-CW-30){p_x[CW-1]}}, p_x, 30'b0};
  assign az_bx = {{(KW-CW-30){p_y[CW-1]}}, p_y, 30'b0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_elx_q   <= {{(KW-SQ_N-20){1'b0}}, sq_root[SQ_N], 20'b0};
      p_ely_q   <= {{(KW-CW-30){p_z[CW-1]}}, p_z, 30'b0};
      p_azx_q   <= p_y[CW-1] ? -az_bx : az_bx;
      p_azy_q   <= p_y[CW-1] ? -az_ay : az_ay;
      p_azang_q <= !p_y[CW-1] ? '0 : (p_x[CW-1] ? -lprc_pkg::ANG_PI : lprc_pkg::ANG_PI);
      p_zero_q  <= (p_x == '0) && (p_y == '0);
      p_ok_q    <= sq_tag[SQ_N][0];
    end
  end

  // elevation and azimuth cordic chains
  logic signed [KW-1:0] el_x [CO_N+1], el_y [CO_N+1];
  logic signed [AW-1:0] el_a [CO_N+1];
  logic                 el_t [CO_N+1];
  logic signed [KW-1:0] az_x [CO_N+1], az_y [CO_N+1];
  logic signed [AW-1:0] az_a [CO_N+1];
  logic                 az_t [CO_N+1];

  assign el_x[0] = p_elx_q;
  assign el_y[0] = p_ely_q;
  assign el_a[0] = '0;
  assign el_t[0] = p_ok_q;
  assign az_x[0] = p_azx_q;
  assign az_y[0] = p_azy_q;
  assign az_a[0] = p_azang_q;
  assign az_t[0] = p_zero_q;

  for (genvar i = 0; i < CO_N; i++) begin : g_cordic
    lprc_cordic_cell #(.STAGE(i), .TAG_W(1)) u_el (
      .clk_i (clk_i),
      .en_i  (en),
      .xv_i  (el_x[i]),
      .yv_i  (el_y[i]),
      .ang_i (el_a[i]),
      .tag_i (el_t[i]),
      .xv_o  (el_x[i+1]),
      .yv_o  (el_y[i+1]),
      .ang_o (el_a[i+1]),
      .tag_o (el_t[i+1])
    );
    lprc_cordic_cell #(.STAGE(i), .TAG_W(1)) u_az (
      .clk_i (clk_i),
      .en_i  (en),
      .xv_i  (az_x[i]),
      .yv_i  (az_y[i]),
      .ang_i (az_a[i]),
      .tag_i (az_t[i]),
      .xv_o  (az_x[i+1]),
      .yv_o  (az_y[i+1]),
      .ang_o (az_a[i+1]),
      .tag_o (az_t[i+1])
    );
  end

  // dividends: |elev + offset| and 2|az - pi/2| + hstep
  logic signed [AW:0]   rnum, cn;
  logic signed [AW-1:0] az_ang;
  logic [AW:0]          rabs, cabs;
  logic [AW+1:0]        cnum;
  logic [DV_N-1:0]      q_rnum_q, q_cnum_q;
  logic                 q_rneg_q, q_cneg_q, q_ok_q;

  assign az_ang = az_t[CO_N] ? '0 : az_a[CO_N];
  assign rnum   = {el_a[CO_N][AW-1], el_a[CO_N]}
                + {{(AW-26){elev_offset_q[26]}}, elev_offset_q};
  assign cn     = {az_ang[AW-1], az_ang} - lprc_pkg::ANG_PI_HALF;
  assign rabs   = rnum[AW] ? -rnum : rnum;
  assign cabs   = cn[AW] ? -cn : cn;
  assign cnum   = {cabs, 1'b0} + (AW+2)'(horiz_step_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_rnum_q <= rabs[DV_N-1:0];
      q_cnum_q <= cnum[DV_N-1:0];
      q_rneg_q <= rnum[AW];
      q_cneg_q <= cn[AW];
      q_ok_q   <= el_t[CO_N];
    end
  end

  // row and column divider chains
  logic [lprc_pkg::DIV_DEN_W-1:0] rd_den, cd_den;
  logic [DV_N-1:0]                rd_num [DV_N+1], rd_quo [DV_N+1];
  logic [lprc_pkg::DIV_DEN_W-1:0] rd_rem [DV_N+1];
  logic [1:0]                     rd_tag [DV_N+1];
  logic [DV_N-1:0]                cd_num [DV_N+1], cd_quo [DV_N+1];
  logic [lprc_pkg::DIV_DEN_W-1:0] cd_rem [DV_N+1];
  logic                           cd_tag [DV_N+1];

  assign rd_den    = {1'b0, vert_step_q};
  assign cd_den    = {horiz_step_q, 1'b0};
  assign rd_num[0] = q_rnum_q;
  assign rd_quo[0] = '0;
  assign rd_rem[0] = '0;
  assign rd_tag[0] = {q_ok_q, q_rneg_q};
  assign cd_num[0] = q_cnum_q;
  assign cd_quo[0] = '0;
  assign cd_rem[0] = '0;
  assign cd_tag[0] = q_cneg_q;

  for (genvar i = 0; i < DV_N; i++) begin : g_div
    lprc_div_cell #(.TAG_W(2)) u_row (
      .clk_i (clk_i),
      .en_i  (en),
      .den_i (rd_den),
      .num_i (rd_num[i]),
      .rem_i (rd_rem[i]),
      .quo_i (rd_quo[i]),
      .tag_i (rd_tag[i]),
      .num_o (rd_num[i+1]),
      .rem_o (rd_rem[i+1]),
      .quo_o (rd_quo[i+1]),
      .tag_o (rd_tag[i+1])
    );
    lprc_div_cell #(.TAG_W(1)) u_col (
      .clk_i (clk_i),
      .en_i  (en),
      .den_i (cd_den),
      .num_i (cd_num[i]),
      .rem_i (cd_rem[i]),
      .quo_i (cd_quo[i]),
      .tag_i (cd_tag[i]),
      .num_o (cd_num[i+1]),
      .rem_o (cd_rem[i+1]),
      .quo_o (cd_quo[i+1]),
      .tag_o (cd_tag[i+1])
    );
  end

  // row and column, range checks
  logic signed [DV_N+1:0] colv, cols_s;
  logic                   f_ok_d;
  logic                   f_ok_q;
  logic [6:0]             f_row_q;
  logic [11:0]            f_col_q;

  assign cols_s = signed'((DV_N+2)'(cols));

  always_comb begin
    colv = signed'((DV_N+2)'(cols[12:1]));
    colv = cd_tag[DV_N] ? colv + signed'({2'b0, cd_quo[DV_N]})
                        : colv - signed'({2'b0, cd_quo[DV_N]});
    if (cols[0] && colv < 0) begin
      colv = colv + 1;
    end
    if (colv >= cols_s) begin
      colv = colv - cols_s;
    end
    f_ok_d = rd_tag[DV_N][1]
          && (vert_step_q != '0) && (horiz_step_q != '0)
          && !(rd_tag[DV_N][0] && (rd_quo[DV_N] != '0))
          && (rd_quo[DV_N] < DV_N'(rows))
          && (colv >= 0) && (colv < cols_s);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_ok_q  <= f_ok_d;
      f_row_q <= f_ok_d ? rd_quo[DV_N][6:0] : '0;
      f_col_q <= f_ok_d ? colv[11:0] : '0;
    end
  end

  // result formatting
  logic [19:0] inc_idx;
  assign inc_idx = 20'(f_row_q) * 20'(cols) + 20'(f_col_q);

  // output register with skid entry
  logic        out_v_q, out_v_d, skid_v_d;
  logic        take, out_load, out_from_skid, skid_load;
  logic        out_res_q, skid_res_q;
  logic [5:0]  out_row_q, skid_row_q;
  logic [10:0] out_col_q, skid_col_q;
  logic [16:0] out_idx_q, skid_idx_q;

  always_comb begin
    take          = out_v_q && !out_stall_i;
    out_v_d       = out_v_q;
    skid_v_d      = skid_v_q;
    out_load      = 1'b0;
    out_from_skid = 1'b0;
    skid_load     = 1'b0;
    if (skid_v_q) begin
      if (take) begin
        out_from_skid = 1'b1;
        skid_v_d      = 1'b0;
      end
    end else if (!out_v_q || take) begin
      out_load = 1'b1;
      out_v_d  = vld_q[NSTG-1];
    end else if (vld_q[NSTG-1]) begin
      skid_load = 1'b1;
      skid_v_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_from_skid) begin
      out_res_q <= skid_res_q;
      out_row_q <= skid_row_q;
      out_col_q <= skid_col_q;
      out_idx_q <= skid_idx_q;
    end else if (out_load) begin
      out_res_q <= f_ok_q;
      out_row_q <= f_row_q[5:0];
      out_col_q <= f_col_q[10:0];
      out_idx_q <= inc_idx[16:0];
    end
    if (skid_load) begin
      skid_res_q <= f_ok_q;
      skid_row_q <= f_row_q[5:0];
      skid_col_q <= f_col_q[10:0];
      skid_idx_q <= inc_idx[16:0];
    end
  end

  assign out_valid_o  = out_v_q;
  assign valid_res_o  = out_res_q;
  assign row_o        = out_row_q;
  assign column_o     = out_col_q;
  assign cell_index_o = out_idx_q;

endmodule

### hw/rtl/lprc_sqrt_cell.sv
module lprc_sqrt_cell #(
  parameter int unsigned TAG_W = 1
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [lprc_pkg::SQRT_RAD_W-1:0]      rad_i,
  input  logic [lprc_pkg::SQRT_ROOT_W-1:0]     root_i,
  input  logic [lprc_pkg::SQRT_REM_W-1:0]      rem_i,
  input  logic [TAG_W-1:0]                     tag_i,
  output logic [lprc_pkg::SQRT_RAD_W-1:0]      rad_o,
  output logic [lprc_pkg::SQRT_ROOT_W-1:0]     root_o,
  output logic [lprc_pkg::SQRT_REM_W-1:0]      rem_o,
  output logic [TAG_W-1:0]                     tag_o
);

  localparam int unsigned RW = lprc_pkg::SQRT_RAD_W;
  localparam int unsigned QW = lprc_pkg::SQRT_ROOT_W;
  localparam int unsigned MW = lprc_pkg::SQRT_REM_W;

  logic [MW+1:0] cur;
  logic [MW+1:0] trial;
  logic          ge;
  logic [MW+1:0] diff;

  // one root bit: bring down two radicand bits and try root*4+1
  assign cur   = {rem_i, rad_i[RW-1 -: 2]};
  assign trial = (MW+2)'({root_i, 2'b01});
  assign ge    = (cur >= trial);
  assign diff  = cur - trial;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[RW-3:0], 2'b00};
      root_o <= {root_i[QW-2:0], ge};
      rem_o  <= ge ? diff[MW-1:0] : cur[MW-1:0];
      tag_o  <= tag_i;
    end
  end

endmodule

### hw/rtl/lprc_cordic_cell.sv
module lprc_cordic_cell #(
  parameter int unsigned STAGE = 0,
  parameter int unsigned TAG_W = 1
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [lprc_pkg::CORD_W-1:0]     xv_i,
  input  logic signed [lprc_pkg::CORD_W-1:0]     yv_i,
  input  logic signed [lprc_pkg::ANG_W-1:0]      ang_i,
  input  logic [TAG_W-1:0]                       tag_i,
  output logic signed [lprc_pkg::CORD_W-1:0]     xv_o,
  output logic signed [lprc_pkg::CORD_W-1:0]     yv_o,
  output logic signed [lprc_pkg::ANG_W-1:0]      ang_o,
  output logic [TAG_W-1:0]                       tag_o
);

  localparam logic signed [lprc_pkg::ANG_W-1:0] ATAN = lprc_pkg::atan_entry(STAGE);

  logic signed [lprc_pkg::CORD_W-1:0] dx;
  logic signed [lprc_pkg::CORD_W-1:0] dy;
  logic                               pos;

  // rotate toward the x axis by atan(2^-STAGE)
  assign dx  = yv_i >>> STAGE;
  assign dy  = xv_i >>> STAGE;
  assign pos = (yv_i > 0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xv_o  <= pos ? xv_i + dx : xv_i - dx;
      yv_o  <= pos ? yv_i - dy : yv_i + dy;
      ang_o <= pos ? ang_i + ATAN : ang_i - ATAN;
      tag_o <= tag_i;
    end
  end

endmodule

### hw/rtl/lprc_div_cell.sv
module lprc_div_cell #(
  parameter int unsigned TAG_W = 1
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [lprc_pkg::DIV_DEN_W-1:0]    den_i,
  input  logic [lprc_pkg::DIV_NUM_W-1:0]    num_i,
  input  logic [lprc_pkg::DIV_DEN_W-1:0]    rem_i,
  input  logic [lprc_pkg::DIV_NUM_W-1:0]    quo_i,
  input  logic [TAG_W-1:0]                  tag_i,
  output logic [lprc_pkg::DIV_NUM_W-1:0]    num_o,
  output logic [lprc_pkg::DIV_DEN_W-1:0]    rem_o,
  output logic [lprc_pkg::DIV_NUM_W-1:0]    quo_o,
  output logic [TAG_W-1:0]                  tag_o
);

  localparam int unsigned NW = lprc_pkg::DIV_NUM_W;
  localparam int unsigned DW = lprc_pkg::DIV_DEN_W;

  logic [DW:0] cur;
  logic        ge;
  logic [DW:0] diff;

  // one quotient bit per cell, restoring
  assign cur  = {rem_i, num_i[NW-1]};
  assign ge   = (cur >= {1'b0, den_i});
  assign diff = cur - {1'b0, den_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= {num_i[NW-2:0], 1'b0};
      rem_o <= ge ? diff[DW-1:0] : cur[DW-1:0];
      quo_o <= {quo_i[NW-2:0], ge};
      tag_o <= tag_i;
    end
  end

endmodule

### hw/rtl/lprc_checker.sv
module lprc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        valid_res_o,
  input logic [5:0]  row_o,
  input logic [10:0] column_o,
  input logic [16:0] cell_index_o
);

  // a stalled result stays and holds its cell index and valid_res
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_index_o)
                                   && $stable(valid_res_o))
    else $error("stalled result changed");

  // a dropped point carries zero fields
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> row_o == '0 && column_o == '0
                                    && cell_index_o == '0)
    else $error("dropped point has nonzero fields");

  // input stalls only while a result is held
  a_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // skid fills only when the output was stalled
  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output back pressure");

endmodule

bind lidar_point_to_range_cell lprc_checker u_lprc_checker (.*);
